// ===== design/fts_pkg.sv =====
`timescale 1ns / 1ps

package fts_pkg;

    localparam int MAX_THREADS = 64;
    localparam int IDX_W       = $clog2(MAX_THREADS);
    localparam int CNT_W       = $clog2(MAX_THREADS + 1);

    localparam int MODE_W   = 2;
    localparam int KIND_W   = 2;
    localparam int TID_W    = 6;
    localparam int STATUS_W = 3;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic [1:0] {
        TS_FREE    = 2'd0,
        TS_READY   = 2'd1,
        TS_RUNNING = 2'd2,
        TS_EXITED  = 2'd3
    } tstat_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_CREATE = 2'd0,
        MODE_YIELD  = 2'd1,
        MODE_EXIT   = 2'd2,
        MODE_KILL   = 2'd3
    } mode_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_NAMED = 2'd0,
        KIND_ANY   = 2'd1,
        KIND_SELF  = 2'd2
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_INVALID = 3'd1,
        ST_NONE    = 3'd2,
        ST_NOMORE  = 3'd3,
        ST_HALTED  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        Q_HOLD  = 2'd0,
        Q_PUSH  = 2'd1,
        Q_SHIFT = 2'd2,
        Q_ROT   = 2'd3
    } qop_t;

    typedef enum logic [2:0] {
        S_IDLE   = 3'd0,
        S_SCAN   = 3'd1,
        S_DECIDE = 3'd2,
        S_QUEUE  = 3'd3,
        S_FIN    = 3'd4
    } state_t;

    typedef struct packed {
        logic   en;
        idx_t   idx;
        tstat_t val;
    } tbl_wr_t;

    typedef struct packed {
        logic    rotate;
        tbl_wr_t w0;
        tbl_wr_t w1;
        tbl_wr_t w2;
        logic    kill_en;
        idx_t    kill_idx;
        logic    kill_val;
    } tbl_cmd_t;

    typedef struct packed {
        qop_t op;
        idx_t id;
    } q_cmd_t;

    typedef struct packed {
        tstat_t scan_status;
        logic   scan_kill;
        logic   head_occ;
        idx_t   head_id;
    } view_t;

endpackage

// ===== design/fifo_thread_scheduler.sv =====
`timescale 1ns / 1ps

// Channel   Handshake             Payload
// request   in_valid / in_stall   mode, target_kind, target_tid
// result    out_valid / out_stall status, result_tid, running_tid
//
// A request to a halted scheduler goes from S_IDLE straight to S_FIN, which loads its result. Any
// other request rotates the thread table ring once through its first cell (S_SCAN), decides in
// S_DECIDE, makes its queue moves in S_QUEUE (the longest is a removal by id that turns the ready
// queue once) and loads the result in S_FIN, which waits while a held result is stalled; the
// scheduler then returns to S_IDLE to take the next request.
// After reset thread 0 runs, all other entries are free and the ready queue is empty.
// A stalled result is held in the output register; the next request is taken meanwhile.

module fifo_thread_scheduler import fts_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [MODE_W-1:0]   mode,
    input  logic [KIND_W-1:0]   target_kind,
    input  logic [TID_W-1:0]    target_tid,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [STATUS_W-1:0] status,
    output logic [TID_W-1:0]    result_tid,
    output logic [TID_W-1:0]    running_tid
);

    tstat_t   cell_status [MAX_THREADS];
    logic     cell_kill   [MAX_THREADS];
    idx_t     q_id        [MAX_THREADS];
    logic     q_occ       [MAX_THREADS];
    tbl_cmd_t tbl;
    q_cmd_t   qcmd;
    view_t    view;
    status_t  out_status;

    assign view.scan_status = cell_status[0];
    assign view.scan_kill   = cell_kill[0];
    assign view.head_occ    = q_occ[0];
    assign view.head_id     = q_id[0];

    for (genvar i = 0; i < MAX_THREADS; i++)
    begin : g_cell
        logic left_occ;
        idx_t right_id;
        logic right_occ;

        if (i == 0)
        begin : g_first
            assign left_occ = 1'b1;
        end
        else
        begin : g_rest
            assign left_occ = q_occ[i-1];
        end

        if (i == MAX_THREADS - 1)
        begin : g_last
            assign right_id  = '0;
            assign right_occ = 1'b0;
        end
        else
        begin : g_inner
            assign right_id  = q_id[i+1];
            assign right_occ = q_occ[i+1];
        end

        fts_thread_cell u_thread
        (
            .clk         (clk),
            .rst_n       (rst_n),
            .my_idx      (IDX_W'(i)),
            .init_status ((i == 0) ? TS_RUNNING : TS_FREE),
            .cmd         (tbl),
            .nb_status   (cell_status[(i + 1) % MAX_THREADS]),
            .nb_kill     (cell_kill[(i + 1) % MAX_THREADS]),
            .status      (cell_status[i]),
            .kill        (cell_kill[i])
        );

        fts_queue_cell u_queue
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (qcmd),
            .head_id   (q_id[0]),
            .left_occ  (left_occ),
            .right_id  (right_id),
            .right_occ (right_occ),
            .id        (q_id[i]),
            .occ       (q_occ[i])
        );
    end

    fts_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .target_kind (target_kind),
        .target_tid  (target_tid),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (out_status),
        .result_tid  (result_tid),
        .running_tid (running_tid),
        .view        (view),
        .tbl         (tbl),
        .qcmd        (qcmd)
    );

    assign status = out_status;

endmodule

// ===== design/fts_thread_cell.sv =====
`timescale 1ns / 1ps

module fts_thread_cell import fts_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  idx_t     my_idx,
    input  tstat_t   init_status,
    input  tbl_cmd_t cmd,
    input  tstat_t   nb_status,
    input  logic     nb_kill,
    output tstat_t   status,
    output logic     kill
);

    tstat_t status_reg;
    tstat_t status_next;
    logic   kill_reg;
    logic   kill_next;

    // While rotating, the cell takes its right neighbor's entry; writes land only when the
    // ring is back in place, so my_idx names the entry held here.
    always_comb
    begin
        status_next = status_reg;
        kill_next   = kill_reg;
        if (cmd.rotate)
        begin
            status_next = nb_status;
            kill_next   = nb_kill;
        end
        else
        begin
            if (cmd.w0.en && cmd.w0.idx == my_idx)
            begin
                status_next = cmd.w0.val;
            end
            if (cmd.w1.en && cmd.w1.idx == my_idx)
            begin
                status_next = cmd.w1.val;
            end
            if (cmd.w2.en && cmd.w2.idx == my_idx)
            begin
                status_next = cmd.w2.val;
            end
            if (cmd.kill_en && cmd.kill_idx == my_idx)
            begin
                kill_next = cmd.kill_val;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg <= init_status;
            kill_reg   <= 1'b0;
        end
        else
        begin
            status_reg <= status_next;
            kill_reg   <= kill_next;
        end
    end

    assign status = status_reg;
    assign kill   = kill_reg;

endmodule

// ===== design/fts_queue_cell.sv =====
`timescale 1ns / 1ps

module fts_queue_cell import fts_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  q_cmd_t cmd,
    input  idx_t   head_id,
    input  logic   left_occ,
    input  idx_t   right_id,
    input  logic   right_occ,
    output idx_t   id,
    output logic   occ
);

    idx_t id_reg;
    idx_t id_next;
    logic occ_reg;
    logic occ_next;

    always_comb
    begin
        id_next  = id_reg;
        occ_next = occ_reg;
        unique case (cmd.op)
            Q_HOLD:
            begin
            end
            Q_PUSH:
            begin
                // Only the first empty slot takes the new id; a full queue drops it.
                if (!occ_reg && left_occ)
                begin
                    id_next  = cmd.id;
                    occ_next = 1'b1;
                end
            end
            Q_SHIFT:
            begin
                id_next  = right_id;
                occ_next = right_occ;
            end
            Q_ROT:
            begin
                // The last occupied slot receives the old head.
                if (right_occ)
                begin
                    id_next = right_id;
                end
                else if (occ_reg)
                begin
                    id_next = head_id;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
    end

    assign id  = id_reg;
    assign occ = occ_reg;

endmodule

// ===== design/fts_ctrl.sv =====
`timescale 1ns / 1ps

module fts_ctrl import fts_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [MODE_W-1:0]   mode,
    input  logic [KIND_W-1:0]   target_kind,
    input  logic [TID_W-1:0]    target_tid,
    output logic                out_valid,
    input  logic                out_stall,
    output status_t             status,
    output logic [TID_W-1:0]    result_tid,
    output logic [TID_W-1:0]    running_tid,
    input  view_t               view,
    output tbl_cmd_t            tbl,
    output q_cmd_t              qcmd
);

    localparam idx_t K_LAST = IDX_W'(MAX_THREADS - 1);
    localparam cnt_t CNT_MAX = CNT_W'(MAX_THREADS);

    state_t            state_reg, state_next;
    idx_t              k_reg, k_next;
    mode_t             mode_reg, mode_next;
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [TID_W-1:0]  tid_reg, tid_next;
    idx_t              cur_reg, cur_next;
    logic              halted_reg, halted_next;
    cnt_t              count_reg, count_next;
    logic              free_found_reg, free_found_next;
    idx_t              free_id_reg, free_id_next;
    logic              exit_found_reg, exit_found_next;
    idx_t              exit_id_reg, exit_id_next;
    tstat_t            tid_st_reg, tid_st_next;
    logic              kill_cur_reg, kill_cur_next;
    logic              pop_reg, pop_next;
    cnt_t              rm_left_reg, rm_left_next;
    idx_t              rm_id_reg, rm_id_next;
    logic              push_reg, push_next;
    idx_t              push_id_reg, push_id_next;
    status_t           res_status_reg, res_status_next;
    idx_t              res_tid_reg, res_tid_next;
    logic              out_valid_reg, out_valid_next;
    status_t           out_status_reg, out_status_next;
    idx_t              out_tid_reg, out_tid_next;
    idx_t              out_run_reg, out_run_next;

    idx_t tid_idx;
    logic tid_oob;
    logic exit_path;

    assign tid_idx   = IDX_W'(tid_reg);
    assign tid_oob   = int'(tid_reg) >= MAX_THREADS;
    assign exit_path = (mode_reg == MODE_EXIT) || (mode_reg == MODE_YIELD && kill_cur_reg);

    always_comb
    begin
        status_t st;
        idx_t    rid;

        st              = ST_OK;
        rid             = '0;
        state_next      = state_reg;
        k_next          = k_reg;
        mode_next       = mode_reg;
        kind_next       = kind_reg;
        tid_next        = tid_reg;
        cur_next        = cur_reg;
        halted_next     = halted_reg;
        count_next      = count_reg;
        free_found_next = free_found_reg;
        free_id_next    = free_id_reg;
        exit_found_next = exit_found_reg;
        exit_id_next    = exit_id_reg;
        tid_st_next     = tid_st_reg;
        kill_cur_next   = kill_cur_reg;
        pop_next        = pop_reg;
        rm_left_next    = rm_left_reg;
        rm_id_next      = rm_id_reg;
        push_next       = push_reg;
        push_id_next    = push_id_reg;
        res_status_next = res_status_reg;
        res_tid_next    = res_tid_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_tid_next    = out_tid_reg;
        out_run_next    = out_run_reg;
        tbl             = '0;
        qcmd            = '0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next       = mode_t'(mode);
                    kind_next       = target_kind;
                    tid_next        = target_tid;
                    k_next          = '0;
                    free_found_next = 1'b0;
                    exit_found_next = 1'b0;
                    tid_st_next     = TS_FREE;
                    kill_cur_next   = 1'b0;
                    if (halted_reg)
                    begin
                        res_status_next = ST_HALTED;
                        res_tid_next    = '0;
                        state_next      = S_FIN;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // The ring turns once; entry k sits in the first cell during step k.
                tbl.rotate = 1'b1;
                if (view.scan_status == TS_FREE && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_id_next    = k_reg;
                end
                if (view.scan_status == TS_EXITED && !exit_found_reg)
                begin
                    exit_found_next = 1'b1;
                    exit_id_next    = k_reg;
                end
                if (k_reg == tid_idx)
                begin
                    tid_st_next = view.scan_status;
                end
                if (k_reg == cur_reg)
                begin
                    kill_cur_next = view.scan_kill;
                end
                if (k_reg == K_LAST)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end

            S_DECIDE:
            begin
                if (mode_reg == MODE_CREATE)
                begin
                    if (!free_found_reg)
                    begin
                        st = ST_NOMORE;
                    end
                    else
                    begin
                        tbl.w0.en    = 1'b1;
                        tbl.w0.idx   = free_id_reg;
                        tbl.w0.val   = TS_READY;
                        tbl.kill_en  = 1'b1;
                        tbl.kill_idx = free_id_reg;
                        tbl.kill_val = 1'b0;
                        push_next    = 1'b1;
                        push_id_next = free_id_reg;
                        rid          = free_id_reg;
                    end
                end
                else if (exit_path)
                begin
                    if (!view.head_occ)
                    begin
                        halted_next = 1'b1;
                        st          = ST_HALTED;
                    end
                    else
                    begin
                        tbl.w0.en  = exit_found_reg;
                        tbl.w0.idx = exit_id_reg;
                        tbl.w0.val = TS_FREE;
                        tbl.w1.en  = 1'b1;
                        tbl.w1.idx = cur_reg;
                        tbl.w1.val = TS_EXITED;
                        tbl.w2.en  = 1'b1;
                        tbl.w2.idx = view.head_id;
                        tbl.w2.val = TS_RUNNING;
                        cur_next   = view.head_id;
                        pop_next   = 1'b1;
                        rid        = view.head_id;
                    end
                end
                else if (mode_reg == MODE_YIELD)
                begin
                    unique case (kind_reg)
                        KIND_SELF:
                        begin
                            rid = cur_reg;
                        end
                        KIND_ANY:
                        begin
                            if (!view.head_occ || view.head_id == cur_reg)
                            begin
                                st = ST_NONE;
                            end
                            else
                            begin
                                tbl.w0.en    = exit_found_reg;
                                tbl.w0.idx   = exit_id_reg;
                                tbl.w0.val   = TS_FREE;
                                tbl.w1.en    = 1'b1;
                                tbl.w1.idx   = view.head_id;
                                tbl.w1.val   = TS_RUNNING;
                                tbl.w2.en    = 1'b1;
                                tbl.w2.idx   = cur_reg;
                                tbl.w2.val   = TS_READY;
                                pop_next     = 1'b1;
                                push_next    = 1'b1;
                                push_id_next = cur_reg;
                                cur_next     = view.head_id;
                                rid          = view.head_id;
                            end
                        end
                        KIND_NAMED:
                        begin
                            if (!tid_oob && tid_idx == cur_reg)
                            begin
                                rid = cur_reg;
                            end
                            else if (tid_oob || tid_st_reg != TS_READY)
                            begin
                                st = ST_INVALID;
                            end
                            else
                            begin
                                tbl.w0.en    = exit_found_reg;
                                tbl.w0.idx   = exit_id_reg;
                                tbl.w0.val   = TS_FREE;
                                tbl.w1.en    = 1'b1;
                                tbl.w1.idx   = tid_idx;
                                tbl.w1.val   = TS_RUNNING;
                                tbl.w2.en    = 1'b1;
                                tbl.w2.idx   = cur_reg;
                                tbl.w2.val   = TS_READY;
                                rm_left_next = count_reg;
                                rm_id_next   = tid_idx;
                                push_next    = 1'b1;
                                push_id_next = cur_reg;
                                cur_next     = tid_idx;
                                rid          = tid_idx;
                            end
                        end
                        default:
                        begin
                            st = ST_INVALID;
                        end
                    endcase
                end
                else
                begin
                    if (tid_oob || tid_st_reg == TS_FREE || tid_idx == cur_reg)
                    begin
                        st = ST_INVALID;
                    end
                    else
                    begin
                        tbl.kill_en  = 1'b1;
                        tbl.kill_idx = tid_idx;
                        tbl.kill_val = 1'b1;
                        rid          = tid_idx;
                    end
                end
                res_status_next = st;
                res_tid_next    = (st == ST_OK) ? rid : '0;
                state_next      = S_QUEUE;
            end

            S_QUEUE:
            begin
                if (pop_reg)
                begin
                    qcmd.op    = Q_SHIFT;
                    pop_next   = 1'b0;
                    count_next = count_reg - 1'b1;
                end
                else if (rm_left_reg != '0)
                begin
                    // Removal by id: every queued id passes the head once; the target
                    // is dropped there and the rest go back to the tail in order.
                    if (view.head_id == rm_id_reg)
                    begin
                        qcmd.op    = Q_SHIFT;
                        count_next = count_reg - 1'b1;
                    end
                    else
                    begin
                        qcmd.op = Q_ROT;
                    end
                    rm_left_next = rm_left_reg - 1'b1;
                end
                else if (push_reg)
                begin
                    qcmd.op   = Q_PUSH;
                    qcmd.id   = push_id_reg;
                    push_next = 1'b0;
                    if (count_reg < CNT_MAX)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
                else
                begin
                    state_next = S_FIN;
                end
            end

            S_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_tid_next    = res_tid_reg;
                    out_run_next    = cur_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            k_reg          <= '0;
            mode_reg       <= MODE_CREATE;
            kind_reg       <= '0;
            tid_reg        <= '0;
            cur_reg        <= '0;
            halted_reg     <= 1'b0;
            count_reg      <= '0;
            free_found_reg <= 1'b0;
            free_id_reg    <= '0;
            exit_found_reg <= 1'b0;
            exit_id_reg    <= '0;
            tid_st_reg     <= TS_FREE;
            kill_cur_reg   <= 1'b0;
            pop_reg        <= 1'b0;
            rm_left_reg    <= '0;
            rm_id_reg      <= '0;
            push_reg       <= 1'b0;
            push_id_reg    <= '0;
            res_status_reg <= ST_OK;
            res_tid_reg    <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_OK;
            out_tid_reg    <= '0;
            out_run_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            k_reg          <= k_next;
            mode_reg       <= mode_next;
            kind_reg       <= kind_next;
            tid_reg        <= tid_next;
            cur_reg        <= cur_next;
            halted_reg     <= halted_next;
            count_reg      <= count_next;
            free_found_reg <= free_found_next;
            free_id_reg    <= free_id_next;
            exit_found_reg <= exit_found_next;
            exit_id_reg    <= exit_id_next;
            tid_st_reg     <= tid_st_next;
            kill_cur_reg   <= kill_cur_next;
            pop_reg        <= pop_next;
            rm_left_reg    <= rm_left_next;
            rm_id_reg      <= rm_id_next;
            push_reg       <= push_next;
            push_id_reg    <= push_id_next;
            res_status_reg <= res_status_next;
            res_tid_reg    <= res_tid_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_tid_reg    <= out_tid_next;
            out_run_reg    <= out_run_next;
        end
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign result_tid  = TID_W'(out_tid_reg);
    assign running_tid = TID_W'(out_run_reg);

endmodule

// ===== design/fts_checker.sv =====
`timescale 1ns / 1ps

module fts_checker import fts_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic [MODE_W-1:0]   mode,
    input logic [KIND_W-1:0]   target_kind,
    input logic [TID_W-1:0]    target_tid,
    input logic                out_valid,
    input logic                out_stall,
    input logic [STATUS_W-1:0] status,
    input logic [TID_W-1:0]    result_tid,
    input logic [TID_W-1:0]    running_tid
);

    logic seen_halt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_halt_reg <= 1'b0;
        end
        else if (out_valid && !out_stall && status == ST_HALTED)
        begin
            seen_halt_reg <= 1'b1;
        end
    end

    // A waiting result keeps its value until it is taken.
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(result_tid)
            && $stable(running_tid))
        else $error("stalled result changed");

    // Only a successful request names a thread.
    a_tid_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> result_tid == '0)
        else $error("result_tid nonzero on failed request");

    // One request at a time: the block stalls right after taking a request.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second request taken while busy");

    // Once halted, the scheduler answers every later request as halted.
    a_halt_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        seen_halt_reg && out_valid |-> status == ST_HALTED)
        else $error("halted scheduler answered a request");

    // After a halt the running thread no longer changes.
    a_halt_running_stable: assert property (@(posedge clk) disable iff (!rst_n)
        seen_halt_reg && out_valid && $past(out_valid) |-> $stable(running_tid))
        else $error("running thread changed after halt");

endmodule

bind fifo_thread_scheduler fts_checker u_fts_checker (.*);

// ===== tb/sv/fifo_thread_scheduler_test.sv =====
`timescale 1ns / 1ps

module fifo_thread_scheduler_test;
    import fts_pkg::*;

    localparam logic [KIND_W-1:0] KIND_BAD = 2'd3;
    localparam int RANDOM_ITEMS = 1580;
    localparam int PHASE_LEN    = 250;
    localparam int LONG_HOLD    = 600;
    localparam int DRAIN_WAIT   = 2 * MAX_THREADS + 8;

    typedef struct {
        status_t status;
        idx_t    result;
        idx_t    running;
    } sched_result_t;

    class sched_scoreboard;
        tstat_t        tbl [MAX_THREADS];
        bit            killed [MAX_THREADS];
        idx_t          ready_q [$];
        idx_t          cur;
        bit            halted;
        sched_result_t pending_results [$];
        int            errors;

        function new();
            foreach (tbl[i])
            begin
                tbl[i] = TS_FREE;
                killed[i] = 1'b0;
            end
            tbl[0] = TS_RUNNING;
            cur = '0;
            halted = 1'b0;
            errors = 0;
        endfunction

        function void drop_from_queue(idx_t id);
            foreach (ready_q[i])
            begin
                if (ready_q[i] == id)
                begin
                    ready_q.delete(i);
                    return;
                end
            end
        endfunction

        function void free_lowest_exited();
            for (int i = 0; i < MAX_THREADS; i++)
            begin
                if (tbl[i] == TS_EXITED)
                begin
                    drop_from_queue(idx_t'(i));
                    tbl[i] = TS_FREE;
                    return;
                end
            end
        endfunction

        // Retires the running thread in favor of the queue head; halts on an empty queue.
        function status_t retire_current(output idx_t res);
            idx_t head;
            res = '0;
            if (ready_q.size() == 0)
            begin
                halted = 1'b1;
                return ST_HALTED;
            end
            head = ready_q[0];
            free_lowest_exited();
            tbl[cur] = TS_EXITED;
            tbl[head] = TS_RUNNING;
            cur = head;
            drop_from_queue(head);
            res = head;
            return ST_OK;
        endfunction

        function void switch_to(idx_t to);
            idx_t prev;
            prev = cur;
            drop_from_queue(to);
            free_lowest_exited();
            tbl[to] = TS_RUNNING;
            tbl[prev] = TS_READY;
            if (ready_q.size() < MAX_THREADS)
                ready_q.push_back(prev);
            cur = to;
        endfunction

        function void note_request(logic [MODE_W-1:0] m, logic [KIND_W-1:0] kind,
                                   logic [TID_W-1:0] tid);
            sched_result_t e;
            status_t       st;
            idx_t          res;
            int            i;
            st = ST_OK;
            res = '0;
            if (halted)
                st = ST_HALTED;
            else
            begin
                case (mode_t'(m))
                    MODE_CREATE:
                    begin
                        for (i = 0; i < MAX_THREADS; i++)
                            if (tbl[i] == TS_FREE)
                                break;
                        if (i >= MAX_THREADS)
                            st = ST_NOMORE;
                        else
                        begin
                            tbl[i] = TS_READY;
                            killed[i] = 1'b0;
                            if (ready_q.size() < MAX_THREADS)
                                ready_q.push_back(idx_t'(i));
                            res = idx_t'(i);
                        end
                    end
                    MODE_YIELD:
                    begin
                        // A marked thread exits on yield, whatever target it names.
                        if (killed[cur])
                        begin
                            drop_from_queue(cur);
                            st = retire_current(res);
                        end
                        else if (kind == KIND_SELF || (kind == KIND_NAMED && tid == cur))
                            res = cur;
                        else if (kind == KIND_ANY)
                        begin
                            if (ready_q.size() == 0 || ready_q[0] == cur)
                                st = ST_NONE;
                            else
                            begin
                                res = ready_q[0];
                                switch_to(res);
                            end
                        end
                        else if (kind == KIND_NAMED)
                        begin
                            if (int'(tid) >= MAX_THREADS || tbl[tid] != TS_READY)
                                st = ST_INVALID;
                            else
                            begin
                                res = tid;
                                switch_to(tid);
                            end
                        end
                        else
                            st = ST_INVALID;
                    end
                    MODE_EXIT:
                        st = retire_current(res);
                    default:
                    begin
                        if (int'(tid) >= MAX_THREADS || tbl[tid] == TS_FREE || tid == cur)
                            st = ST_INVALID;
                        else
                        begin
                            killed[tid] = 1'b1;
                            res = tid;
                        end
                    end
                endcase
            end
            if (st != ST_OK)
                res = '0;
            e.status = st;
            e.result = res;
            e.running = cur;
            pending_results.push_back(e);
        endfunction

        function void check_result(logic [STATUS_W-1:0] st, logic [TID_W-1:0] res,
                                   logic [TID_W-1:0] run);
            sched_result_t e;
            if (pending_results.size() == 0)
            begin
                $error("result with no request outstanding: status %0d result_tid %0d",
                       st, res);
                errors++;
                return;
            end
            e = pending_results.pop_front();
            if (st !== e.status)
            begin
                $error("status: expected %0d, actual %0d", e.status, st);
                errors++;
            end
            if (res !== e.result)
            begin
                $error("result_tid: expected %0d, actual %0d", e.result, res);
                errors++;
            end
            if (run !== e.running)
            begin
                $error("running_tid: expected %0d, actual %0d", e.running, run);
                errors++;
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [MODE_W-1:0]   mode;
    logic [KIND_W-1:0]   target_kind;
    logic [TID_W-1:0]    target_tid;
    logic                out_valid;
    logic                out_stall;
    logic [STATUS_W-1:0] status;
    logic [TID_W-1:0]    result_tid;
    logic [TID_W-1:0]    running_tid;

    sched_scoreboard sb = new();
    bit quiet = 1'b0;
    bit hold_request = 1'b0;
    bit hold_done = 1'b0;

    fifo_thread_scheduler DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .target_kind (target_kind),
        .target_tid  (target_tid),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .result_tid  (result_tid),
        .running_tid (running_tid)
    );

    always #5 clk = ~clk;

    task automatic send_request(input logic [MODE_W-1:0] m, input logic [KIND_W-1:0] k,
                                input logic [TID_W-1:0] t);
        in_valid <= 1'b1;
        mode <= m;
        target_kind <= k;
        target_tid <= t;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_request(m, k, t);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    // Requests are drawn against the predicted state so the run never halts early.
    task automatic pick_request(input bit filling, output logic [MODE_W-1:0] m,
                                output logic [KIND_W-1:0] k, output logic [TID_W-1:0] t);
        int r;
        int rk;
        int n;
        r = $urandom_range(0, 99);
        rk = $urandom_range(0, 19);
        n = sb.ready_q.size();
        t = TID_W'($urandom);
        k = (rk == 0) ? KIND_BAD : (rk < 3) ? KIND_SELF : (rk < 8) ? KIND_ANY : KIND_NAMED;
        if (r < (filling ? 50 : 15))
            m = MODE_CREATE;
        else if (r < (filling ? 77 : 50))
        begin
            m = MODE_YIELD;
            if (k == KIND_NAMED && n != 0 && $urandom_range(0, 4) != 0)
                t = sb.ready_q[$urandom_range(0, n - 1)];
        end
        else if (r < 85)
            m = MODE_EXIT;
        else
        begin
            m = MODE_KILL;
            rk = $urandom_range(0, 9);
            if (rk < 5 && n != 0)
                t = sb.ready_q[$urandom_range(0, n - 1)];
            else if (rk < 7)
                t = sb.cur;
        end
        if (n == 0 && (m == MODE_EXIT || (m == MODE_YIELD && sb.killed[sb.cur])))
            m = MODE_CREATE;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(status, result_tid, running_tid);
    end

    initial
    begin
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request && !hold_done)
            begin
                // Long hold-off so the result register fills and the request side stalls.
                hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        logic [MODE_W-1:0] m;
        logic [KIND_W-1:0] k;
        logic [TID_W-1:0]  t;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        mode <= MODE_CREATE;
        target_kind <= KIND_NAMED;
        target_tid <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(MODE_YIELD, KIND_SELF, 6'd0);
        send_request(MODE_YIELD, KIND_ANY, 6'd0);
        send_request(MODE_YIELD, KIND_BAD, 6'd0);
        send_request(MODE_YIELD, KIND_NAMED, 6'd63);
        send_request(MODE_KILL, KIND_NAMED, 6'd0);
        send_request(MODE_KILL, KIND_NAMED, 6'd63);
        send_request(MODE_CREATE, KIND_NAMED, 6'd0);
        send_request(MODE_CREATE, KIND_SELF, 6'd63);
        send_request(MODE_CREATE, KIND_BAD, 6'd21);
        send_request(MODE_YIELD, KIND_NAMED, 6'd0);
        send_request(MODE_YIELD, KIND_ANY, 6'd42);
        send_request(MODE_YIELD, KIND_NAMED, 6'd3);
        send_request(MODE_KILL, KIND_NAMED, 6'd2);
        send_request(MODE_EXIT, KIND_NAMED, 6'd0);
        // Thread 2 now runs with its kill mark set, so this yield retires it.
        send_request(MODE_YIELD, KIND_NAMED, 6'd1);
        send_request(MODE_KILL, KIND_NAMED, 6'd2);
        send_request(MODE_CREATE, KIND_NAMED, 6'd0);
        send_request(MODE_YIELD, KIND_NAMED, 6'd2);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == 400)
                hold_request = 1'b1;
            if (n == RANDOM_ITEMS - 200)
                quiet = 1'b1;
            pick_request(((n / PHASE_LEN) % 2) == 0, m, k, t);
            send_request(m, k, t);
        end

        // Empty the ready queue, halt, then confirm that a halted block answers nothing else.
        while (sb.ready_q.size() != 0)
            send_request(MODE_EXIT, KIND_NAMED, 6'd0);
        send_request(MODE_EXIT, KIND_ANY, 6'd0);
        send_request(MODE_CREATE, KIND_NAMED, 6'd0);
        send_request(MODE_YIELD, KIND_SELF, 6'd0);
        send_request(MODE_KILL, KIND_NAMED, 6'd1);
        in_valid <= 1'b0;

        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== fifo_thread_scheduler.f =====
design/fts_pkg.sv
design/fts_thread_cell.sv
design/fts_queue_cell.sv
design/fts_ctrl.sv
design/fifo_thread_scheduler.sv
design/fts_checker.sv
tb/sv/fifo_thread_scheduler_test.sv
